// ===== hdl/nsc_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Shared character codes, result codes, the result type and small helpers.
// ----------------------------------------------------------------------------
package nsc_pkg;

  localparam int unsigned PrefixW = 40;
  localparam int unsigned NumTypes = 3;

  localparam logic [7:0] CharDollar  = 8'h24;
  localparam logic [7:0] CharStar    = 8'h2A;
  localparam logic [7:0] CharNewline = 8'h0A;

  // Reset prefixes: "GPGGA", "GPVTG", "GPRMC"
  localparam logic [PrefixW-1:0] PrefixResetA = 40'h4750474741;
  localparam logic [PrefixW-1:0] PrefixResetB = 40'h4750565447;
  localparam logic [PrefixW-1:0] PrefixResetC = 40'h4750524D43;

  // Configuration register indexes
  localparam logic [1:0] RegTypeA = 2'd0;
  localparam logic [1:0] RegTypeB = 2'd1;
  localparam logic [1:0] RegTypeC = 2'd2;

  localparam logic [1:0] TypeNone = 2'd3;

  typedef enum logic [1:0] {
    VerdictAccept  = 2'd0,
    VerdictCsumErr = 2'd1,
    VerdictIgnored = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [1:0] sentence_type;
    verdict_e   verdict;
    logic       set_complete;
  } res_t;

  // Character pos (1..5) of a prefix; the first character is the top byte
  function automatic logic [7:0] prefix_char(input logic [PrefixW-1:0] prefix,
                                             input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd1:    c = prefix[39:32];
      3'd2:    c = prefix[31:24];
      3'd3:    c = prefix[23:16];
      3'd4:    c = prefix[15:8];
      3'd5:    c = prefix[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Hex digit decode: bit 4 flags a valid digit, bits 3..0 give its value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, b[3:0]};
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Lowest set bit of a type mask as a type code
  function automatic logic [1:0] lowest_type(input logic [NumTypes-1:0] m);
    logic [1:0] t;
    if (m[0]) begin
      t = 2'd0;
    end else if (m[1]) begin
      t = 2'd1;
    end else if (m[2]) begin
      t = 2'd2;
    end else begin
      t = TypeNone;
    end
    return t;
  endfunction

endpackage

// ===== hdl/nsc_in_if.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence checker input channel
// Valid/ready channel carrying one received byte per item.
// ----------------------------------------------------------------------------
interface nsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/nsc_out_if.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence checker result channel
// Valid/ready channel carrying one sentence report per item.
// ----------------------------------------------------------------------------
interface nsc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] sentence_type;
  logic [1:0] verdict;
  logic       set_complete;

  modport source (output valid, output sentence_type, output verdict,
                  output set_complete, input ready);
  modport sink   (input valid, input sentence_type, input verdict,
                  input set_complete, output ready);
endinterface

// ===== hdl/nmea_sentence_checker.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence checker
// Checks NMEA 0183 sentence types and checksums from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   rx_ch carries one received byte per item. A sentence ends with a newline;
//   for each newline one item leaves on res_ch with the sentence type, the
//   verdict and the set-complete pulse. Other bytes produce no result item.
//   Three 40-bit prefix registers (index 0..2 on the cfg port) pick the
//   sentence types; write them only while the block is idle.
//   Throughput is one byte per cycle except while a newline waits on a
//   stalled res_ch. A byte sits in the input register, where the parser
//   updates its state; a newline result moves on into the output register.
//   A stalled res_ch holds its item; bytes that are not newlines keep
//   flowing, and a newline waits in the input register, with rx_ch.ready
//   low, until the output register frees.
//   Reset restores the default prefixes (GPGGA, GPVTG, GPRMC), clears all
//   held types and the sentence in progress, and empties both registers.
// ----------------------------------------------------------------------------
module nmea_sentence_checker
  import nsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  nsc_in_if.sink             rx_ch,
  nsc_out_if.source          res_ch,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [PrefixW-1:0] cfg_wdata_i
);

  logic [PrefixW-1:0] prefix_a_q, prefix_b_q, prefix_c_q;
  logic               s1_valid_q;
  logic [7:0]         s1_byte_q;
  logic               out_valid_q;
  res_t               out_res_q;
  res_t               res_c;
  logic               s1_nl, s1_adv, out_free;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_a_q <= PrefixResetA;
      prefix_b_q <= PrefixResetB;
      prefix_c_q <= PrefixResetC;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegTypeA: prefix_a_q <= cfg_wdata_i;
        RegTypeB: prefix_b_q <= cfg_wdata_i;
        RegTypeC: prefix_c_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance the input register unless its newline has no output slot
  assign out_free    = !out_valid_q || res_ch.ready;
  assign s1_nl       = (s1_byte_q == CharNewline);
  assign s1_adv      = s1_valid_q && (!s1_nl || out_free);
  assign rx_ch.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rx_ch.ready) begin
      s1_valid_q <= rx_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_ch.valid && rx_ch.ready) begin
      s1_byte_q <= rx_ch.rx_byte;
    end
  end

  nsc_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (s1_adv),
    .byte_i     (s1_byte_q),
    .prefix_a_i (prefix_a_q),
    .prefix_b_i (prefix_b_q),
    .prefix_c_i (prefix_c_q),
    .res_o      (res_c)
  );

  // Output register: load a newline report, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_nl) begin
      out_valid_q <= 1'b1;
    end else if (res_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_nl) begin
      out_res_q <= res_c;
    end
  end

  assign res_ch.valid         = out_valid_q;
  assign res_ch.sentence_type = out_res_q.sentence_type;
  assign res_ch.verdict       = out_res_q.verdict;
  assign res_ch.set_complete  = out_res_q.set_complete;

  // A completed set is only ever reached by an accepted sentence
  a_complete_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ch.valid && res_ch.set_complete |-> res_ch.verdict == VerdictAccept)
    else $error("set_complete without an accepted sentence");

  // An unmatched sentence is always ignored
  a_none_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ch.valid && res_ch.sentence_type == TypeNone
      |-> res_ch.verdict == VerdictIgnored)
    else $error("unmatched sentence not reported as ignored");

  // A newline never overwrites a result still waiting on the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_ch.ready |=> out_valid_q && $stable(out_res_q))
    else $error("pending result overwritten");

  // Input back-pressure only comes from a blocked newline
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ch.ready |-> s1_valid_q && s1_nl && out_valid_q && !res_ch.ready)
    else $error("input stalled without a blocked newline");

endmodule

// ===== hdl/nsc_parser.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence parser
// Per-byte sentence state: prefix match, running XOR, checksum digits and
// held type flags. Produces the sentence report for a newline byte.
// ----------------------------------------------------------------------------
module nsc_parser
  import nsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic [7:0]         byte_i,
  input  logic [PrefixW-1:0] prefix_a_i,
  input  logic [PrefixW-1:0] prefix_b_i,
  input  logic [PrefixW-1:0] prefix_c_i,
  output res_t               res_o
);

  logic [2:0]          pos_q, pos_d;
  logic [NumTypes-1:0] match_q, match_d;
  logic [7:0]          xor_q, xor_d;
  logic                star_q, star_d;
  logic                hex_act_q, hex_act_d;
  logic [7:0]          hex_val_q, hex_val_d;
  logic                hex_ovf_q, hex_ovf_d;
  logic [NumTypes-1:0] held_q, held_d;

  logic [2:0]          pos_n;
  logic [NumTypes-1:0] match_n, matched, fresh, held_n;
  logic [7:0]          xor_n, hex_val_n;
  logic                star_n, hex_act_n, hex_ovf_n, csum_ok;
  logic [4:0]          digit;
  logic [1:0]          type_c;
  verdict_e            verdict_c;
  logic                complete_c;

  assign digit = hex_digit(byte_i);

  // Update the sentence state for this byte
  always_comb begin
    match_n   = match_q;
    hex_act_n = hex_act_q;
    hex_val_n = hex_val_q;
    hex_ovf_n = hex_ovf_q;
    xor_n     = xor_q;
    star_n    = star_q;

    if (pos_q == 3'd0) begin
      if (byte_i != CharDollar) begin
        match_n = '0;
      end
    end else if (pos_q <= 3'd5) begin
      if (prefix_char(prefix_a_i, pos_q) != byte_i) match_n[0] = 1'b0;
      if (prefix_char(prefix_b_i, pos_q) != byte_i) match_n[1] = 1'b0;
      if (prefix_char(prefix_c_i, pos_q) != byte_i) match_n[2] = 1'b0;
    end

    if (hex_act_q) begin
      if (digit[4]) begin
        hex_ovf_n = hex_ovf_q | (hex_val_q[7:4] != 4'd0);
        hex_val_n = {hex_val_q[3:0], digit[3:0]};
      end else begin
        hex_act_n = 1'b0;
      end
    end

    if (pos_q != 3'd0 && !star_q) begin
      if (byte_i == CharStar) begin
        star_n    = 1'b1;
        hex_act_n = 1'b1;
      end else begin
        xor_n = xor_q ^ byte_i;
      end
    end

    pos_n = (pos_q < 3'd6) ? pos_q + 3'd1 : pos_q;
  end

  // Judge the sentence as if this byte were its newline
  always_comb begin
    matched    = (pos_n == 3'd6) ? match_n : '0;
    fresh      = matched & ~held_q;
    csum_ok    = star_n && !hex_ovf_n && (hex_val_n == xor_n);
    held_n     = held_q;
    type_c     = lowest_type(matched);
    verdict_c  = VerdictIgnored;
    if (fresh != '0) begin
      type_c = lowest_type(fresh);
      if (csum_ok) begin
        held_n    = held_q | fresh;
        verdict_c = VerdictAccept;
      end else begin
        verdict_c = VerdictCsumErr;
      end
    end
    complete_c = &held_n;
  end

  assign res_o = '{sentence_type: type_c, verdict: verdict_c,
                   set_complete: complete_c};

  // Next state: clear the sentence on a newline, else keep building it
  always_comb begin
    if (byte_i == CharNewline) begin
      pos_d     = 3'd0;
      match_d   = '1;
      xor_d     = 8'h00;
      star_d    = 1'b0;
      hex_act_d = 1'b0;
      hex_val_d = 8'h00;
      hex_ovf_d = 1'b0;
      held_d    = complete_c ? '0 : held_n;
    end else begin
      pos_d     = pos_n;
      match_d   = match_n;
      xor_d     = xor_n;
      star_d    = star_n;
      hex_act_d = hex_act_n;
      hex_val_d = hex_val_n;
      hex_ovf_d = hex_ovf_n;
      held_d    = held_q;
    end
  end

  // Hold state unless a byte advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= 3'd0;
      match_q   <= '1;
      xor_q     <= 8'h00;
      star_q    <= 1'b0;
      hex_act_q <= 1'b0;
      hex_val_q <= 8'h00;
      hex_ovf_q <= 1'b0;
      held_q    <= '0;
    end else if (adv_i) begin
      pos_q     <= pos_d;
      match_q   <= match_d;
      xor_q     <= xor_d;
      star_q    <= star_d;
      hex_act_q <= hex_act_d;
      hex_val_q <= hex_val_d;
      hex_ovf_q <= hex_ovf_d;
      held_q    <= held_d;
    end
  end

endmodule
